FILE: hw/rtl/latency_window_correlation_trend_unit_defines.svh
// ----------------------------------------------------------------------------
// latency window correlation trend unit: assertion macros
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LATENCY_WINDOW_CORRELATION_TREND_UNIT_DEFINES_SVH
`define LATENCY_WINDOW_CORRELATION_TREND_UNIT_DEFINES_SVH

// same-cycle implication
`define LWCT_ASSERT_HOLD(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lwct: same-cycle check failed");

// next-cycle implication
`define LWCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lwct: next-cycle check failed");

`endif

FILE: hw/rtl/lwct_pkg.sv
// ----------------------------------------------------------------------------
// lwct_pkg
// Shared constants, command/status types and state codes of the unit.
// ----------------------------------------------------------------------------
package lwct_pkg;

  localparam int unsigned SampleW         = 24;
  localparam int unsigned SccW            = 20;
  localparam int unsigned TrendW          = 32;
  localparam int unsigned SccFracW        = 16;
  localparam int unsigned SccQuoW         = 18;
  localparam int unsigned TrendQuoW       = 33;
  localparam int unsigned DefHistoryDepth = 64;

  localparam logic [SccW-1:0]   SccMinusOne = 20'hF0000;
  localparam logic [TrendW-1:0] TrendMax    = 32'h7FFF_FFFF;
  localparam logic [TrendW-1:0] TrendMin    = 32'h8000_0000;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MS_NT0,
    MS_NT2,
    MS_SS,
    MS_S1N2,
    MS_S2N1
  } mul_sel_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_WALK,
    OP_WRAP,
    OP_MUL_LOAD,
    OP_MUL_RUN,
    OP_MUL_STORE,
    OP_DIVA_LOAD,
    OP_DIVB_LOAD,
    OP_DIV_RUN,
    OP_DIVA_STORE,
    OP_DIVB_STORE,
    OP_PUBLISH
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_WRAP,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_DIVA_LOAD,
    ST_DIVA_RUN,
    ST_DIVB_LOAD,
    ST_DIVB_RUN,
    ST_PUBLISH
  } state_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e mul_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic mul_done;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

endpackage

FILE: hw/rtl/lwct_mul.sv
// ----------------------------------------------------------------------------
// lwct_mul
// Shift-add multiplier, one bit of the b operand per cycle while run_i is high.
// ----------------------------------------------------------------------------
module lwct_mul #(
  parameter int unsigned AW = 64,
  parameter int unsigned BW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic          run_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [AW-1:0] prod_o,
  output logic          done_o
);

  localparam int unsigned CntW = $clog2(BW + 1);

  logic [AW-1:0]   a_q;
  logic [BW-1:0]   b_q;
  logic [AW-1:0]   prod_q;
  logic [CntW-1:0] cnt_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= CntW'(BW);
    end else if (run_i && (cnt_q != '0)) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // partial product accumulation
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      prod_q <= '0;
    end else if (run_i && (cnt_q != '0)) begin
      if (b_q[0]) begin
        prod_q <= prod_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign prod_o = prod_q;
  assign done_o = (cnt_q == '0);

endmodule

FILE: hw/rtl/lwct_div.sv
// ----------------------------------------------------------------------------
// lwct_div
// Restoring divider, one quotient bit per cycle while run_i is high, pre-shifted divisor.
// ----------------------------------------------------------------------------
module lwct_div #(
  parameter int unsigned DW = 96,
  parameter int unsigned QW = 33
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic                     run_i,
  input  logic [DW-1:0]            dividend_i,
  input  logic [DW-1:0]            divisor_i,
  input  logic [$clog2(QW+1)-1:0]  steps_i,
  output logic [QW-1:0]            quo_o,
  output logic                     done_o
);

  localparam int unsigned CntW = $clog2(QW + 1);

  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   dvs_q;
  logic [QW-1:0]   quo_q;
  logic [CntW-1:0] cnt_q;
  logic            fits;

  assign fits = (rem_q >= dvs_q);

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= steps_i;
    end else if (run_i && (cnt_q != '0)) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // compare, subtract and shift
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= dividend_i;
      dvs_q <= divisor_i;
      quo_q <= '0;
    end else if (run_i && (cnt_q != '0)) begin
      if (fits) begin
        rem_q <= rem_q - dvs_q;
      end
      quo_q <= {quo_q[QW-2:0], fits};
      dvs_q <= dvs_q >> 1;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = (cnt_q == '0);

endmodule

FILE: hw/rtl/lwct_dp.sv
// ----------------------------------------------------------------------------
// lwct_dp
// Window memory, walk accumulators, shared multiplier and divider, result
// formatting and output register.
// ----------------------------------------------------------------------------
module lwct_dp #(
  parameter int unsigned HistoryDepth = lwct_pkg::DefHistoryDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lwct_pkg::dp_cmd_t                cmd_i,
  input  logic [lwct_pkg::SampleW-1:0]     sample_i,
  input  logic                             out_ready_i,
  output lwct_pkg::dp_sts_t                sts_o,
  output logic                             out_valid_o,
  output logic [lwct_pkg::SccW-1:0]        out_scc_o,
  output logic                             out_degen_o,
  output logic [lwct_pkg::TrendW-1:0]      out_trend_o,
  output logic                             out_tsat_o,
  output logic [$clog2(HistoryDepth+1)-1:0] out_held_o
);

  localparam int unsigned SampleW = lwct_pkg::SampleW;
  localparam int unsigned AddrW   = $clog2(HistoryDepth);
  localparam int unsigned CntW    = $clog2(HistoryDepth + 1);
  localparam int unsigned SumW    = SampleW + AddrW;
  localparam int unsigned SqW     = 2 * SampleW + AddrW;
  localparam int unsigned PW      = SqW + CntW;
  localparam int unsigned HpW     = SumW + CntW;
  localparam int unsigned TNumW   = HpW + 15;
  localparam int unsigned DW      = PW + lwct_pkg::SccQuoW;
  localparam int unsigned QW      = lwct_pkg::TrendQuoW;
  localparam int unsigned StepW   = $clog2(QW + 1);
  localparam logic [CntW-1:0]  Half    = CntW'(HistoryDepth / 2);
  localparam logic [CntW-1:0]  Full    = CntW'(HistoryDepth);
  localparam logic [AddrW-1:0] LastAdr = AddrW'(HistoryDepth - 1);

  logic [SampleW-1:0] mem [HistoryDepth];

  logic [AddrW-1:0]   head_q, rd_ptr_q, head_nxt;
  logic [CntW-1:0]    fill_q, iss_cnt_q, acc_cnt_q, n1, n2;
  logic               rdv_q, accept, issue;
  logic [SampleW-1:0] rd_data_q, x0_q, prev_q, lag_b;
  logic [SumW-1:0]    s_q, s1_q, s2_q;
  logic [SqW-1:0]     t0_q, t2_q;
  logic [2*SampleW-1:0] prod_sq, prod_lag;

  logic [PW-1:0]  nt0_q, nt2_q, ss_q, mul_a, mul_prod;
  logic [SumW-1:0] mul_b;
  logic [HpW-1:0] s1n2_q, s2n1_q;
  logic           mul_done;

  logic           degen_c, sneg_c, tneg_c, tbig_c;
  logic [PW-1:0]  sden, snum;
  logic [HpW-1:0] tmag;
  logic [TNumW-1:0] tnum;
  logic [DW-1:0]  div_dividend, div_divisor;
  logic [StepW-1:0] div_steps;
  logic [QW-1:0]  div_quo;
  logic           div_done;

  logic           degen_q, sneg_q, tneg_q, tbig_q;
  logic [lwct_pkg::SccQuoW-1:0] sq_q;
  logic [QW-1:0]  tq_q;

  logic [lwct_pkg::SccW-1:0]   scc_c;
  logic [lwct_pkg::TrendW-1:0] trend_c;
  logic                        tsat_c;
  logic                        out_valid_q, out_degen_q, out_tsat_q;
  logic [lwct_pkg::SccW-1:0]   out_scc_q;
  logic [lwct_pkg::TrendW-1:0] out_trend_q;
  logic [CntW-1:0]             out_held_q;

  assign accept   = (cmd_i.op == lwct_pkg::OP_ACCEPT);
  assign issue    = (cmd_i.op == lwct_pkg::OP_WALK) && (iss_cnt_q != fill_q);
  assign head_nxt = (head_q == LastAdr) ? '0 : head_q + 1'b1;

  // pointers, counts and read pipeline valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      rd_ptr_q  <= '0;
      iss_cnt_q <= '0;
      acc_cnt_q <= '0;
      rdv_q     <= 1'b0;
    end else begin
      rdv_q <= issue;
      if (accept) begin
        head_q    <= head_nxt;
        rd_ptr_q  <= head_nxt;
        iss_cnt_q <= '0;
        acc_cnt_q <= '0;
        if (fill_q != Full) begin
          fill_q <= fill_q + 1'b1;
        end
      end else begin
        if (issue) begin
          rd_ptr_q  <= (rd_ptr_q == '0) ? LastAdr : rd_ptr_q - 1'b1;
          iss_cnt_q <= iss_cnt_q + 1'b1;
        end
        if (rdv_q) begin
          acc_cnt_q <= acc_cnt_q + 1'b1;
        end
      end
    end
  end

  // window memory, newest word written at the head
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[head_nxt] <= sample_i;
    end
    if (issue) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  // walk products, the lag multiplier also serves the wrap term
  assign lag_b    = (cmd_i.op == lwct_pkg::OP_WRAP) ? x0_q : rd_data_q;
  assign prod_sq  = rd_data_q * rd_data_q;
  assign prod_lag = prev_q * lag_b;

  // sums over the window, newest first
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q  <= '0;
      s1_q <= '0;
      s2_q <= '0;
      t0_q <= '0;
      t2_q <= '0;
    end else if (rdv_q) begin
      if (acc_cnt_q == '0) begin
        x0_q <= rd_data_q;
      end else begin
        t0_q <= t0_q + SqW'(prod_lag);
      end
      s_q  <= s_q + SumW'(rd_data_q);
      t2_q <= t2_q + SqW'(prod_sq);
      if (acc_cnt_q < Half) begin
        s1_q <= s1_q + SumW'(rd_data_q);
      end else begin
        s2_q <= s2_q + SumW'(rd_data_q);
      end
      prev_q <= rd_data_q;
    end else if (cmd_i.op == lwct_pkg::OP_WRAP) begin
      t0_q <= t0_q + SqW'(prod_lag);
    end
  end

  assign n1 = (fill_q < Half) ? fill_q : Half;
  assign n2 = fill_q - n1;

  // multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      lwct_pkg::MS_NT0: begin
        mul_a = PW'(t0_q);
        mul_b = SumW'(fill_q);
      end
      lwct_pkg::MS_NT2: begin
        mul_a = PW'(t2_q);
        mul_b = SumW'(fill_q);
      end
      lwct_pkg::MS_SS: begin
        mul_a = PW'(s_q);
        mul_b = s_q;
      end
      lwct_pkg::MS_S1N2: begin
        mul_a = PW'(s1_q);
        mul_b = SumW'(n2);
      end
      lwct_pkg::MS_S2N1: begin
        mul_a = PW'(s2_q);
        mul_b = SumW'(n1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lwct_mul #(
    .AW (PW),
    .BW (SumW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cmd_i.op == lwct_pkg::OP_MUL_LOAD),
    .run_i  (cmd_i.op == lwct_pkg::OP_MUL_RUN),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod),
    .done_o (mul_done)
  );

  // product capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lwct_pkg::OP_MUL_STORE) begin
      unique case (cmd_i.mul_sel)
        lwct_pkg::MS_NT0:  nt0_q  <= mul_prod;
        lwct_pkg::MS_NT2:  nt2_q  <= mul_prod;
        lwct_pkg::MS_SS:   ss_q   <= mul_prod;
        lwct_pkg::MS_S1N2: s1n2_q <= HpW'(mul_prod);
        lwct_pkg::MS_S2N1: s2n1_q <= HpW'(mul_prod);
        default: ;
      endcase
    end
  end

  // correlation operands: magnitude of n*t0 - S^2 over n*t2 - S^2
  assign degen_c = (nt2_q <= ss_q);
  assign sden    = nt2_q - ss_q;
  assign sneg_c  = (nt0_q < ss_q);
  assign snum    = sneg_c ? (ss_q - nt0_q) : (nt0_q - ss_q);

  // trend operands: 25600 * |s1*n2 - s2*n1| over s2*n1
  assign tneg_c = (s1n2_q < s2n1_q);
  assign tmag   = tneg_c ? (s2n1_q - s1n2_q) : (s1n2_q - s2n1_q);
  assign tnum   = (TNumW'(tmag) << 14) + (TNumW'(tmag) << 13) + (TNumW'(tmag) << 10);
  assign tbig_c = (DW'(tnum) >= (DW'(s2n1_q) << QW));

  // divider operand select
  always_comb begin
    if (cmd_i.op == lwct_pkg::OP_DIVB_LOAD) begin
      div_dividend = DW'(tnum);
      div_divisor  = DW'(s2n1_q) << (QW - 1);
      div_steps    = StepW'(QW);
    end else begin
      div_dividend = DW'(snum) << lwct_pkg::SccFracW;
      div_divisor  = DW'(sden) << (lwct_pkg::SccQuoW - 1);
      div_steps    = StepW'(lwct_pkg::SccQuoW);
    end
  end

  lwct_div #(
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     ((cmd_i.op == lwct_pkg::OP_DIVA_LOAD) ||
                 (cmd_i.op == lwct_pkg::OP_DIVB_LOAD)),
    .run_i      (cmd_i.op == lwct_pkg::OP_DIV_RUN),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .quo_o      (div_quo),
    .done_o     (div_done)
  );

  // division flags and quotients
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lwct_pkg::OP_DIVA_LOAD) begin
      degen_q <= degen_c;
      sneg_q  <= sneg_c;
    end
    if (cmd_i.op == lwct_pkg::OP_DIVB_LOAD) begin
      tneg_q <= tneg_c;
      tbig_q <= tbig_c;
    end
    if (cmd_i.op == lwct_pkg::OP_DIVA_STORE) begin
      sq_q <= div_quo[lwct_pkg::SccQuoW-1:0];
    end
    if (cmd_i.op == lwct_pkg::OP_DIVB_STORE) begin
      tq_q <= div_quo;
    end
  end

  // correlation result, forced to -1 when the spread is zero
  always_comb begin
    if (degen_q) begin
      scc_c = lwct_pkg::SccMinusOne;
    end else if (sneg_q) begin
      scc_c = '0 - lwct_pkg::SccW'(sq_q);
    end else begin
      scc_c = lwct_pkg::SccW'(sq_q);
    end
  end

  // trend result with empty-half, zero-average and clipping cases
  always_comb begin
    trend_c = '0;
    tsat_c  = 1'b0;
    priority if (n2 == '0) begin
      trend_c = '0;
    end else if (s2n1_q == '0) begin
      tsat_c  = 1'b1;
      trend_c = (s1n2_q != '0) ? lwct_pkg::TrendMax : '0;
    end else if (tbig_q) begin
      tsat_c  = 1'b1;
      trend_c = tneg_q ? lwct_pkg::TrendMin : lwct_pkg::TrendMax;
    end else if (!tneg_q) begin
      if (tq_q > {1'b0, lwct_pkg::TrendMax}) begin
        tsat_c  = 1'b1;
        trend_c = lwct_pkg::TrendMax;
      end else begin
        trend_c = tq_q[lwct_pkg::TrendW-1:0];
      end
    end else begin
      if (tq_q > {1'b0, lwct_pkg::TrendMin}) begin
        tsat_c  = 1'b1;
        trend_c = lwct_pkg::TrendMin;
      end else begin
        trend_c = '0 - tq_q[lwct_pkg::TrendW-1:0];
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == lwct_pkg::OP_PUBLISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lwct_pkg::OP_PUBLISH) begin
      out_scc_q   <= scc_c;
      out_degen_q <= degen_q;
      out_trend_q <= trend_c;
      out_tsat_q  <= tsat_c;
      out_held_q  <= fill_q;
    end
  end

  assign sts_o.walk_done = (acc_cnt_q == fill_q);
  assign sts_o.mul_done  = mul_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_scc_o   = out_scc_q;
  assign out_degen_o = out_degen_q;
  assign out_trend_o = out_trend_q;
  assign out_tsat_o  = out_tsat_q;
  assign out_held_o  = out_held_q;

endmodule

FILE: hw/rtl/lwct_ctrl.sv
// ----------------------------------------------------------------------------
// lwct_ctrl
// Sequencer: accept, window walk, five products, two divisions, publish.
// ----------------------------------------------------------------------------
module lwct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  lwct_pkg::dp_sts_t sts_i,
  output logic              in_ready_o,
  output lwct_pkg::dp_cmd_t cmd_o
);

  lwct_pkg::state_e   state_q, state_d;
  lwct_pkg::mul_sel_e sel_q, sel_d;

  // state and product index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lwct_pkg::ST_IDLE;
      sel_q   <= lwct_pkg::MS_NT0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    unique case (state_q)
      lwct_pkg::ST_IDLE: begin
        sel_d = lwct_pkg::MS_NT0;
        if (in_valid_i) begin
          state_d = lwct_pkg::ST_WALK;
        end
      end
      lwct_pkg::ST_WALK: begin
        if (sts_i.walk_done) begin
          state_d = lwct_pkg::ST_WRAP;
        end
      end
      lwct_pkg::ST_WRAP:     state_d = lwct_pkg::ST_MUL_LOAD;
      lwct_pkg::ST_MUL_LOAD: state_d = lwct_pkg::ST_MUL_RUN;
      lwct_pkg::ST_MUL_RUN: begin
        if (sts_i.mul_done) begin
          if (sel_q == lwct_pkg::MS_S2N1) begin
            state_d = lwct_pkg::ST_DIVA_LOAD;
          end else begin
            sel_d   = lwct_pkg::mul_sel_e'(sel_q + 3'd1);
            state_d = lwct_pkg::ST_MUL_LOAD;
          end
        end
      end
      lwct_pkg::ST_DIVA_LOAD: state_d = lwct_pkg::ST_DIVA_RUN;
      lwct_pkg::ST_DIVA_RUN: begin
        if (sts_i.div_done) begin
          state_d = lwct_pkg::ST_DIVB_LOAD;
        end
      end
      lwct_pkg::ST_DIVB_LOAD: state_d = lwct_pkg::ST_DIVB_RUN;
      lwct_pkg::ST_DIVB_RUN: begin
        if (sts_i.div_done) begin
          state_d = lwct_pkg::ST_PUBLISH;
        end
      end
      lwct_pkg::ST_PUBLISH: begin
        if (!sts_i.out_busy) begin
          state_d = lwct_pkg::ST_IDLE;
        end
      end
      default: state_d = lwct_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o.mul_sel = sel_q;
    cmd_o.op      = lwct_pkg::OP_NONE;
    in_ready_o    = 1'b0;
    unique case (state_q)
      lwct_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = lwct_pkg::OP_ACCEPT;
        end
      end
      lwct_pkg::ST_WALK:      cmd_o.op = lwct_pkg::OP_WALK;
      lwct_pkg::ST_WRAP:      cmd_o.op = lwct_pkg::OP_WRAP;
      lwct_pkg::ST_MUL_LOAD:  cmd_o.op = lwct_pkg::OP_MUL_LOAD;
      lwct_pkg::ST_MUL_RUN: begin
        cmd_o.op = sts_i.mul_done ? lwct_pkg::OP_MUL_STORE : lwct_pkg::OP_MUL_RUN;
      end
      lwct_pkg::ST_DIVA_LOAD: cmd_o.op = lwct_pkg::OP_DIVA_LOAD;
      lwct_pkg::ST_DIVA_RUN: begin
        cmd_o.op = sts_i.div_done ? lwct_pkg::OP_DIVA_STORE : lwct_pkg::OP_DIV_RUN;
      end
      lwct_pkg::ST_DIVB_LOAD: cmd_o.op = lwct_pkg::OP_DIVB_LOAD;
      lwct_pkg::ST_DIVB_RUN: begin
        cmd_o.op = sts_i.div_done ? lwct_pkg::OP_DIVB_STORE : lwct_pkg::OP_DIV_RUN;
      end
      lwct_pkg::ST_PUBLISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = lwct_pkg::OP_PUBLISH;
        end
      end
      default: cmd_o.op = lwct_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: hw/rtl/latency_window_correlation_trend_unit.sv
// Latency window correlation and trend unit.
// Input stream (s_axis): one 24-bit latency sample per word. The sample is
// pushed into a newest-first window of HISTORY_DEPTH entries with a fill count.
// Output stream (m_axis): one word per sample carrying the cyclic serial
// correlation coefficient (Q4.16), the newer-versus-older half trend in
// percent (8 fraction bits), the number of held samples, and two flags in
// tuser: correlation degenerate and trend saturated.
// Timing: one sample is worked on at a time, through the window walk (one
// memory read a cycle), five products on a bit-serial multiplier and two
// restoring divisions of 18 and 33 steps.
// s_axis_tready is high while the sequencer is idle; a finished word sits in
// the output register, so the next sample is taken and worked on while the
// receiver stalls, and only publication waits for the register to drain.
// Reset empties the window (fill count zero) and drops any pending word; the
// window memory is not cleared, entries are read only once written.
`include "latency_window_correlation_trend_unit_defines.svh"
// ----------------------------------------------------------------------------
// latency_window_correlation_trend_unit
// Top level: sequencer, datapath and stream packing.
// ----------------------------------------------------------------------------
module latency_window_correlation_trend_unit #(
  parameter int unsigned HISTORY_DEPTH = lwct_pkg::DefHistoryDepth,
  localparam int unsigned CntW     = $clog2(HISTORY_DEPTH + 1),
  localparam int unsigned OutDataW =
    ((lwct_pkg::SccW + lwct_pkg::TrendW + CntW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // [23:0] sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,  // scc, trend, samples_held, zero fill
  output logic [1:0]           m_axis_tuser   // [0] scc_degenerate, [1] trend_saturated
);

  lwct_pkg::dp_cmd_t cmd;
  lwct_pkg::dp_sts_t sts;

  logic [lwct_pkg::SccW-1:0]   out_scc;
  logic [lwct_pkg::TrendW-1:0] out_trend;
  logic [CntW-1:0]             out_held;
  logic                        out_degen, out_tsat;

  lwct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  lwct_dp #(
    .HistoryDepth (HISTORY_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_scc_o   (out_scc),
    .out_degen_o (out_degen),
    .out_trend_o (out_trend),
    .out_tsat_o  (out_tsat),
    .out_held_o  (out_held)
  );

  // stream packing
  assign m_axis_tdata = OutDataW'({out_held, out_trend, out_scc});
  assign m_axis_tuser = {out_tsat, out_degen};

  // checks
  `LWCT_ASSERT_HOLD(a_publish_free, cmd.op == lwct_pkg::OP_PUBLISH, !sts.out_busy)
  `LWCT_ASSERT_HOLD(a_accept_hs, cmd.op == lwct_pkg::OP_ACCEPT, s_axis_tvalid && s_axis_tready)
  `LWCT_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `LWCT_ASSERT_NEXT(a_publish_valid, cmd.op == lwct_pkg::OP_PUBLISH, m_axis_tvalid)

endmodule

FILE: sim/tb_latency_window_correlation_trend_unit.sv
// ----------------------------------------------------------------------------
// tb_latency_window_correlation_trend_unit
// Streams latency samples into the unit and checks every output word,
// field by field, against a model of the window kept in the bench. Idle and
// stall pressure change over four phases of the run.
// ----------------------------------------------------------------------------
module tb_latency_window_correlation_trend_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth    = 64;
  localparam int unsigned Half     = Depth / 2;
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned OutDataW =
    ((lwct_pkg::SccW + lwct_pkg::TrendW + CntW + 7) / 8) * 8;
  localparam int unsigned NumItems = 500;
  localparam int unsigned MaxCycles = 1_500_000;
  localparam int unsigned DrainCycles = 400;

  // one expected output word
  typedef struct packed {
    logic [lwct_pkg::SccW-1:0]   scc;
    logic                        degen;
    logic [lwct_pkg::TrendW-1:0] trend;
    logic                        sat;
    logic [CntW-1:0]             held;
  } corr_trend_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  latency_window_correlation_trend_unit #(.HISTORY_DEPTH(Depth)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  logic [23:0]   sample_q[$];
  corr_trend_t   expected_q[$];
  logic [23:0]   win_model[Depth];
  int unsigned   held_model;
  int unsigned   sent_cnt;
  int unsigned   err_cnt;
  int unsigned   cycle_cnt;
  logic          in_fire;
  logic          stim_done;

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // push one sample into the window and work out the word it causes
  function automatic corr_trend_t window_predict(input logic [23:0] smp);
    corr_trend_t  r;
    logic [63:0]  t0, t2, ssum, x, prev;
    logic [127:0] nt0, nt2, s2, num, den, quo;
    longint       s1, s2t, n1, n2, tnum, tden, tq;
    int unsigned  n;
    for (int i = Depth - 1; i > 0; i--) win_model[i] = win_model[i-1];
    win_model[0] = smp;
    if (held_model < Depth) held_model++;
    n = held_model;
    // correlation sums with the wrap term
    t0 = 0; t2 = 0; ssum = 0; prev = 0;
    for (int i = 0; i < n; i++) begin
      x = 64'(win_model[i]);
      if (i > 0) t0 += prev * x;
      ssum += x;
      t2 += x * x;
      prev = x;
    end
    t0 += prev * 64'(win_model[0]);
    nt0 = 128'(n) * 128'(t0);
    nt2 = 128'(n) * 128'(t2);
    s2  = 128'(ssum) * 128'(ssum);
    if (nt2 <= s2) begin
      r.scc = lwct_pkg::SccMinusOne;
      r.degen = 1'b1;
    end else begin
      den = nt2 - s2;
      num = (nt0 < s2) ? s2 - nt0 : nt0 - s2;
      quo = (num << 16) / den;
      r.degen = 1'b0;
      if (nt0 < s2) r.scc = (quo > 128'd524288) ? 20'h80000 : 20'(-quo);
      else r.scc = (quo > 128'd524287) ? 20'h7FFFF : 20'(quo);
    end
    // trend between the halves
    n1 = (n < Half) ? n : Half;
    n2 = n - n1;
    r.trend = '0;
    r.sat = 1'b0;
    if (n2 != 0) begin
      s1 = 0; s2t = 0;
      for (int i = 0; i < n1; i++) s1 += longint'(win_model[i]);
      for (int i = Half; i < Half + n2; i++) s2t += longint'(win_model[i]);
      tnum = 25600 * (s1 * n2 - s2t * n1);
      tden = s2t * n1;
      if (tden == 0) begin
        r.sat = 1'b1;
        r.trend = (tnum > 0) ? lwct_pkg::TrendMax : '0;
      end else begin
        tq = tnum / tden;
        if (tq > 64'sd2147483647) begin
          r.trend = lwct_pkg::TrendMax;
          r.sat = 1'b1;
        end else if (tq < -64'sd2147483648) begin
          r.trend = lwct_pkg::TrendMin;
          r.sat = 1'b1;
        end else begin
          r.trend = 32'(tq);
        end
      end
    end
    r.held = CntW'(n);
    return r;
  endfunction

  // input acceptance and prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(window_predict(s_axis_tdata));
    end
  end

  // output checking
  always @(posedge clk_i) begin
    corr_trend_t exp_w, got_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_w.scc   = m_axis_tdata[19:0];
      got_w.trend = m_axis_tdata[51:20];
      got_w.held  = m_axis_tdata[52 +: CntW];
      got_w.degen = m_axis_tuser[0];
      got_w.sat   = m_axis_tuser[1];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got_w);
        err_cnt++;
      end else begin
        exp_w = expected_q.pop_front();
        if (got_w.scc !== exp_w.scc) begin
          $display("%0t: scc exp %h got %h", $time, exp_w.scc, got_w.scc);
          err_cnt++;
        end
        if (got_w.degen !== exp_w.degen) begin
          $display("%0t: scc_degenerate exp %b got %b", $time, exp_w.degen, got_w.degen);
          err_cnt++;
        end
        if (got_w.trend !== exp_w.trend) begin
          $display("%0t: trend exp %h got %h", $time, exp_w.trend, got_w.trend);
          err_cnt++;
        end
        if (got_w.sat !== exp_w.sat) begin
          $display("%0t: trend_saturated exp %b got %b", $time, exp_w.sat, got_w.sat);
          err_cnt++;
        end
        if (got_w.held !== exp_w.held) begin
          $display("%0t: samples_held exp %0d got %0d", $time, exp_w.held, got_w.held);
          err_cnt++;
        end
      end
    end
  end

  // sample driver and receiver stalls, four pressure phases
  always @(negedge clk_i) begin
    int unsigned phase, idle_pct, stall_pct;
    logic hold_off;
    if (rst_ni) begin
      phase = (sent_cnt * 4) / NumItems;
      idle_pct  = (phase == 1) ? 80 : (phase == 3) ? 33 : 0;
      stall_pct = (phase == 2) ? 80 : (phase == 3) ? 33 : 0;
      // pause once mid run until every word has drained
      hold_off = (sent_cnt == NumItems / 2) && (expected_q.size() != 0);
      if (!s_axis_tvalid || in_fire) begin
        if (sample_q.size() != 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_q.pop_front();
          sent_cnt++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("tb_latency_window_correlation_trend_unit: done, errors");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned kind, len, total;
    logic [23:0] base;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    held_model = 0;
    sent_cnt = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    stim_done = 1'b0;
    foreach (win_model[i]) win_model[i] = '0;
    // single sample, constant samples, extremes
    sample_q = '{24'd5, 24'd5, 24'd5, 24'd0, 24'hFFFFFF, 24'h000001, 24'hAAAAAA,
                 24'h555555, 24'hFFFFFF, 24'd0, 24'h800000, 24'h7FFFFF};
    // tiny then zero older half, then large newer samples for overflow and saturation
    sample_q.push_back(24'd1);
    repeat (39) sample_q.push_back(24'd0);
    repeat (25) sample_q.push_back(24'hFFFFFF);
    // random runs with shaped content
    total = sample_q.size();
    while (total < NumItems) begin
      kind = $urandom_range(5);
      len  = $urandom_range(1, 40);
      base = 24'($urandom);
      for (int i = 0; i < len && total < NumItems; i++) begin
        case (kind)
          0: sample_q.push_back(base);
          1: sample_q.push_back(24'd0);
          2: sample_q.push_back(24'hFFFFFF);
          3: sample_q.push_back(24'($urandom_range(3)));
          4: sample_q.push_back(24'($urandom));
          default: sample_q.push_back(base ^ 24'($urandom_range(255)));
        endcase
        total++;
      end
    end
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (sample_q.size() == 0 && !s_axis_tvalid && expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("tb_latency_window_correlation_trend_unit: done, clean");
    end else begin
      $display("tb_latency_window_correlation_trend_unit: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/lwct_pkg.sv
hw/rtl/lwct_mul.sv
hw/rtl/lwct_div.sv
hw/rtl/lwct_dp.sv
hw/rtl/lwct_ctrl.sv
hw/rtl/latency_window_correlation_trend_unit.sv
sim/tb_latency_window_correlation_trend_unit.sv
